[rtl/core/rsme_pkg.sv]
// ----------------------------------------------------------------------------
// rsme_pkg
// Types and constants shared by the register machine execute block.
// ----------------------------------------------------------------------------
package rsme_pkg;

	localparam int unsigned NumRegs    = 5;
	localparam int unsigned FrameSize  = 6;
	localparam int unsigned StackDepth = 64;
	localparam int unsigned ValueBits  = 32;
	localparam int unsigned AddrBits   = 16;
	localparam int unsigned SpBits     = $clog2(StackDepth + 1);
	localparam int unsigned SaBits     = $clog2(StackDepth);
	localparam int unsigned DivCntBits = $clog2(ValueBits + 1);

	typedef logic [2:0] action_t;
	localparam action_t ACT_ADD = 3'd0;
	localparam action_t ACT_SUB = 3'd1;
	localparam action_t ACT_MUL = 3'd2;
	localparam action_t ACT_DIV = 3'd3;
	localparam action_t ACT_CALL = 3'd4;
	localparam action_t ACT_RET = 3'd5;

	typedef logic [1:0] err_t;
	localparam err_t ERR_NONE = 2'd0;
	localparam err_t ERR_DIV0 = 2'd1;
	localparam err_t ERR_OVF  = 2'd2;

	typedef struct packed {
		logic [2:0]            action;
		logic [2:0]            dest_index;
		logic                  source_is_register;
		logic [2:0]            source_index;
		logic signed [31:0]    immediate;
		logic [15:0]           current_address;
		logic [15:0]           callee_address;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        next_address;
		logic               done_res;
		logic signed [31:0] return_value;
		logic [1:0]         error;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ALU,
		ST_DIV,
		ST_DIVFIN,
		ST_PUSH,
		ST_POP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       alu_write;
		logic       div_start;
		logic       div_step;
		logic       div_write;
		logic       push;
		logic       call_fin;
		logic       pop_read;
		logic       pop_write;
		logic       ret_fin;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		action_t action;
		logic    div_zero;
		logic    div_last;
		logic    overflow;
		logic    stack_empty;
		logic    push_last;
		logic    pop_last;
	} status_t;

endpackage

[rtl/core/register_stack_machine_execute_top.sv]
// ----------------------------------------------------------------------------
// register_stack_machine_execute_top
// Executes one decoded instruction of a five-register machine per transfer.
// ----------------------------------------------------------------------------
// One instruction is taken at a time. Add, subtract and multiply, a division
// by zero, a call that would overflow the stack, a return with an empty stack
// and the unused action codes go from the ALU state straight to the output
// state. Division steps through the divider, which retires one quotient bit
// per cycle; call writes the six frame entries through the single stack
// memory write port, and return reads the frame back through the registered
// read port. A new input is taken in the cycle after a result is loaded into
// the output register; while that register holds a stalled result, the next
// result waits.
module register_stack_machine_execute_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rsme_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rsme_pkg::out_item_t  out_data
);

	rsme_pkg::cmd_t cmd;
	rsme_pkg::status_t status;

	rsme_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_full(out_valid), .out_taken(!out_stall), .status(status), .cmd(cmd)
	);

	rsme_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .cmd(cmd),
		.status(status), .result(out_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

endmodule

[rtl/core/rsme_ctrl.sv]
// ----------------------------------------------------------------------------
// rsme_ctrl
// Controller state machine sequencing arithmetic, division, call and return.
// ----------------------------------------------------------------------------
module rsme_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                out_full,
	input  logic                out_taken,
	input  rsme_pkg::status_t   status,
	output rsme_pkg::cmd_t      cmd
);

	rsme_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsme_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			rsme_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = rsme_pkg::ST_ALU;
				end
			end
			rsme_pkg::ST_ALU: begin
				case (status.action)
					rsme_pkg::ACT_ADD, rsme_pkg::ACT_SUB, rsme_pkg::ACT_MUL: begin
						cmd.alu_write = 1'b1;
						state_d = rsme_pkg::ST_OUT;
					end
					rsme_pkg::ACT_DIV: begin
						if (status.div_zero) begin
							state_d = rsme_pkg::ST_OUT;
						end else begin
							cmd.div_start = 1'b1;
							state_d = rsme_pkg::ST_DIV;
						end
					end
					rsme_pkg::ACT_CALL: begin
						state_d = status.overflow ? rsme_pkg::ST_OUT : rsme_pkg::ST_PUSH;
					end
					rsme_pkg::ACT_RET: begin
						if (status.stack_empty) begin
							state_d = rsme_pkg::ST_OUT;
						end else begin
							cmd.pop_read = 1'b1;
							state_d = rsme_pkg::ST_POP;
						end
					end
					default: state_d = rsme_pkg::ST_OUT;
				endcase
			end
			rsme_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = rsme_pkg::ST_DIVFIN;
				end
			end
			rsme_pkg::ST_DIVFIN: begin
				cmd.div_write = 1'b1;
				state_d = rsme_pkg::ST_OUT;
			end
			rsme_pkg::ST_PUSH: begin
				cmd.push = 1'b1;
				if (status.push_last) begin
					cmd.call_fin = 1'b1;
					state_d = rsme_pkg::ST_OUT;
				end
			end
			rsme_pkg::ST_POP: begin
				cmd.pop_write = 1'b1;
				if (status.pop_last) begin
					cmd.ret_fin = 1'b1;
					state_d = rsme_pkg::ST_OUT;
				end else begin
					cmd.pop_read = 1'b1;
				end
			end
			rsme_pkg::ST_OUT: begin
				if (!out_full || out_taken) begin
					cmd.out_load = 1'b1;
					state_d = rsme_pkg::ST_IDLE;
				end
			end
			default: state_d = rsme_pkg::ST_IDLE;
		endcase
	end

endmodule

[rtl/core/rsme_dp.sv]
// ----------------------------------------------------------------------------
// rsme_dp
// Datapath: register file, call stack memory, divider and result register.
// ----------------------------------------------------------------------------
module rsme_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rsme_pkg::in_item_t   in_data,
	input  rsme_pkg::cmd_t       cmd,
	output rsme_pkg::status_t    status,
	output rsme_pkg::out_item_t  result
);

	localparam int unsigned VB = rsme_pkg::ValueBits;
	localparam int unsigned AB = rsme_pkg::AddrBits;
	localparam int unsigned SPB = rsme_pkg::SpBits;
	localparam int unsigned SAB = rsme_pkg::SaBits;

	rsme_pkg::in_item_t item_q;
	logic [VB-1:0] regs_q [rsme_pkg::NumRegs];
	logic [VB-1:0] stack_mem [rsme_pkg::StackDepth];
	logic [VB-1:0] rd_q;
	logic [SPB-1:0] sp_q;
	logic [2:0] cnt_q;
	logic [VB-1:0] a_val, b_val, alu_r;
	logic [AB-1:0] next_q, caller_q;
	logic done_q;
	rsme_pkg::err_t err_q;

	logic [VB-1:0] rem_q, quo_q, dvs_q;
	logic neg_q;
	logic [rsme_pkg::DivCntBits-1:0] dcnt_q;
	logic [VB:0] trial;
	logic [VB-1:0] rem_sh;
	logic err_div;

	always_comb begin
		a_val = (item_q.dest_index < 3'(rsme_pkg::NumRegs)) ? regs_q[item_q.dest_index] : '0;
		if (item_q.source_is_register) begin
			b_val = (item_q.source_index < 3'(rsme_pkg::NumRegs)) ?
				regs_q[item_q.source_index] : '0;
		end else begin
			b_val = VB'(item_q.immediate);
		end
		case (item_q.action)
			rsme_pkg::ACT_ADD: alu_r = a_val + b_val;
			rsme_pkg::ACT_SUB: alu_r = a_val - b_val;
			default: alu_r = a_val * b_val;
		endcase
	end

	assign rem_sh = {rem_q[VB-2:0], quo_q[VB-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, dvs_q};

	always_comb begin
		status.action = item_q.action;
		status.div_zero = (b_val == '0);
		status.div_last = (dcnt_q == rsme_pkg::DivCntBits'(1));
		status.overflow = (32'(sp_q) + rsme_pkg::FrameSize > rsme_pkg::StackDepth);
		status.stack_empty = (32'(sp_q) < rsme_pkg::FrameSize);
		status.push_last = (cnt_q == 3'd5);
		status.pop_last = (cnt_q == 3'd0);
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[sp_q[SAB-1:0]] <= (cnt_q == 3'd5) ? VB'(item_q.current_address) :
				regs_q[cnt_q];
		end
		rd_q <= stack_mem[sp_q[SAB-1:0] - SAB'(1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			for (int i = 0; i < rsme_pkg::NumRegs; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			if (cmd.alu_write && item_q.dest_index < 3'(rsme_pkg::NumRegs)) begin
				regs_q[item_q.dest_index] <= alu_r;
			end
			if (cmd.div_write && item_q.dest_index < 3'(rsme_pkg::NumRegs)) begin
				regs_q[item_q.dest_index] <= neg_q ? -quo_q : quo_q;
			end
			if (cmd.push) begin
				sp_q <= sp_q + SPB'(1);
			end
			if (cmd.call_fin) begin
				for (int i = 0; i < rsme_pkg::NumRegs; i++) begin
					if (3'(i) != item_q.source_index) begin
						regs_q[i] <= '0;
					end
				end
			end
			if (cmd.pop_read) begin
				sp_q <= sp_q - SPB'(1);
			end
			if (cmd.pop_write && cnt_q != 3'd5 && cnt_q != item_q.dest_index) begin
				regs_q[cnt_q] <= rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
			next_q <= in_data.current_address + AB'(1);
			done_q <= (in_data.action == rsme_pkg::ACT_RET) && status.stack_empty;
			err_q <= (in_data.action == rsme_pkg::ACT_CALL && status.overflow) ?
				rsme_pkg::ERR_OVF : rsme_pkg::ERR_NONE;
			cnt_q <= 3'd0;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= a_val[VB-1] ? -a_val : a_val;
			dvs_q <= b_val[VB-1] ? -b_val : b_val;
			neg_q <= a_val[VB-1] ^ b_val[VB-1];
			dcnt_q <= rsme_pkg::DivCntBits'(VB);
		end
		if (cmd.div_step) begin
			if (!trial[VB]) begin
				rem_q <= trial[VB-1:0];
				quo_q <= {quo_q[VB-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[VB-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q - rsme_pkg::DivCntBits'(1);
		end
		if (cmd.push) begin
			cnt_q <= cnt_q + 3'd1;
		end
		if (cmd.call_fin) begin
			next_q <= item_q.callee_address + AB'(1);
		end
		if (cmd.pop_read && !cmd.pop_write) begin
			cnt_q <= 3'd5;
		end
		if (cmd.pop_write) begin
			if (cnt_q == 3'd5) begin
				caller_q <= rd_q[AB-1:0];
			end
			cnt_q <= cnt_q - 3'd1;
		end
		if (cmd.ret_fin) begin
			next_q <= caller_q + AB'(1);
		end
	end

	assign err_div = item_q.action == rsme_pkg::ACT_DIV && status.div_zero;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result.next_address <= next_q;
			result.done_res <= done_q;
			result.return_value <= done_q ? a_val : '0;
			result.error <= err_div ? rsme_pkg::ERR_DIV0 : err_q;
		end
	end

endmodule

[rtl/core/rsme_checker.sv]
// ----------------------------------------------------------------------------
// rsme_port_checks
// Port-level checks of the register machine execute block.
// ----------------------------------------------------------------------------
module rsme_port_checks (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input rsme_pkg::out_item_t  out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while busy");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.error != 2'd3)
		else $error("bad error code");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> out_data.error == rsme_pkg::ERR_NONE)
		else $error("done with error");

endmodule

bind register_stack_machine_execute_top rsme_port_checks u_rsme_port_checks (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

[sim/rsme_checker.sv]
// ----------------------------------------------------------------------------
// rsme_checker
// Watches both channels of the register machine execute block, predicts each
// result from the accepted instructions and compares the whole result with it.
// ----------------------------------------------------------------------------
module rsme_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  rsme_pkg::in_item_t            in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  rsme_pkg::out_item_t           out_data,
	output int                            fail_count,
	output int                            pending
);

	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] regs [rsme_pkg::NumRegs];
	logic [31:0] frames [rsme_pkg::StackDepth];
	int unsigned depth;
	rsme_pkg::out_item_t expected_q [$];

	function automatic logic [31:0] read_reg(logic [2:0] idx);
		return (idx < rsme_pkg::NumRegs) ? regs[idx] : 32'd0;
	endfunction

	function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	task automatic execute(rsme_pkg::in_item_t it);
		rsme_pkg::out_item_t r;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] v;
		logic [15:0] caller;
		r = '0;
		r.next_address = it.current_address + 16'd1;
		if (it.action <= rsme_pkg::ACT_DIV) begin
			a = read_reg(it.dest_index);
			b = it.source_is_register ? read_reg(it.source_index) : it.immediate;
			v = a;
			case (it.action)
				rsme_pkg::ACT_ADD: v = a + b;
				rsme_pkg::ACT_SUB: v = a - b;
				rsme_pkg::ACT_MUL: v = a * b;
				default: begin
					if (b == 0)
						r.error = rsme_pkg::ERR_DIV0;
					else
						v = quotient(a, b);
				end
			endcase
			if (r.error == rsme_pkg::ERR_NONE && it.dest_index < rsme_pkg::NumRegs)
				regs[it.dest_index] = v;
		end else if (it.action == rsme_pkg::ACT_CALL) begin
			if (depth + rsme_pkg::FrameSize > rsme_pkg::StackDepth) begin
				r.error = rsme_pkg::ERR_OVF;
			end else begin
				for (int i = 0; i < rsme_pkg::NumRegs; i++) begin
					frames[depth++] = regs[i];
					if (i != it.source_index)
						regs[i] = '0;
				end
				frames[depth++] = 32'(it.current_address);
				r.next_address = it.callee_address + 16'd1;
			end
		end else if (it.action == rsme_pkg::ACT_RET) begin
			if (depth >= rsme_pkg::FrameSize) begin
				caller = 16'(frames[--depth]);
				for (int i = rsme_pkg::NumRegs - 1; i >= 0; i--) begin
					v = frames[--depth];
					if (i != it.dest_index)
						regs[i] = v;
				end
				r.next_address = caller + 16'd1;
			end else begin
				r.done_res = 1'b1;
				r.return_value = read_reg(it.dest_index);
			end
		end
		expected_q.push_back(r);
	endtask

	assign pending = expected_q.size();

	initial begin
		fail_count = 0;
		depth = 0;
		foreach (regs[i])
			regs[i] = '0;
	end

	always @(posedge clk) begin
		rsme_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (out_data !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, out_data);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				execute(in_data);
		end
	end
endmodule

[sim/tb_register_stack_machine_execute_top.sv]
// ----------------------------------------------------------------------------
// tb_register_stack_machine_execute_top
// Drives directed and random instructions with random idling and a long
// output hold-off; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_register_stack_machine_execute_top;

	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	rsme_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	rsme_pkg::out_item_t out_data;
	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;
	int cycle_count;

	register_stack_machine_execute_top i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

	rsme_checker i_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("tb_register_stack_machine_execute_top failed");
				$finish;
			end
		end
	end

	// The receiver stalls at random, or for a whole stretch when asked.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	function automatic rsme_pkg::in_item_t make_item(rsme_pkg::action_t act, logic [2:0] dst,
			logic src_reg, logic [2:0] src, logic [31:0] imm);
		rsme_pkg::in_item_t it;
		it.action = act;
		it.dest_index = dst;
		it.source_is_register = src_reg;
		it.source_index = src;
		it.immediate = imm;
		it.current_address = 16'($urandom);
		it.callee_address = 16'($urandom);
		return it;
	endfunction

	function automatic rsme_pkg::in_item_t random_item();
		rsme_pkg::in_item_t it;
		int pick;
		logic [31:0] imm;
		pick = $urandom_range(99);
		case ($urandom_range(5))
			0: imm = 32'h8000_0000;
			1: imm = 32'hFFFF_FFFF;
			2: imm = 32'd0;
			3: imm = $urandom_range(15);
			default: imm = $urandom;
		endcase
		it = make_item(rsme_pkg::action_t'($urandom_range(3)), 3'($urandom_range(4)),
			1'($urandom_range(1)), 3'($urandom_range(4)), imm);
		if (pick < 12) begin
			it.action = rsme_pkg::ACT_CALL;
		end else if (pick < 22) begin
			it.action = rsme_pkg::ACT_RET;
		end else if (pick < 25) begin
			it.action = rsme_pkg::action_t'($urandom_range(6, 7));
		end else if (pick < 28) begin
			it.dest_index = 3'($urandom_range(5, 7));
			it.source_index = 3'($urandom_range(5, 7));
		end
		return it;
	endfunction

	task automatic send(rsme_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		while (in_stall)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	initial begin
		rsme_pkg::in_item_t it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(make_item(rsme_pkg::ACT_RET, 3'd0, 1'b0, 3'd0, '0));
		send(make_item(rsme_pkg::ACT_ADD, 3'd0, 1'b0, 3'd0, 32'h7FFF_FFFF));
		send(make_item(rsme_pkg::ACT_ADD, 3'd0, 1'b0, 3'd0, 32'd1));
		send(make_item(rsme_pkg::ACT_SUB, 3'd1, 1'b0, 3'd0, 32'd1));
		send(make_item(rsme_pkg::ACT_MUL, 3'd1, 1'b1, 3'd0, '0));
		send(make_item(rsme_pkg::ACT_ADD, 3'd2, 1'b0, 3'd0, 32'hFFFF_FFFF));
		send(make_item(rsme_pkg::ACT_DIV, 3'd0, 1'b1, 3'd2, '0));
		send(make_item(rsme_pkg::ACT_DIV, 3'd0, 1'b0, 3'd0, '0));
		send(make_item(rsme_pkg::ACT_DIV, 3'd2, 1'b1, 3'd4, '0));
		send(make_item(rsme_pkg::ACT_ADD, 3'd3, 1'b0, 3'd0, -32'sd7));
		send(make_item(rsme_pkg::ACT_DIV, 3'd3, 1'b0, 3'd0, 32'd2));
		send(make_item(rsme_pkg::ACT_ADD, 3'd6, 1'b1, 3'd7, 32'd5));
		send(make_item(rsme_pkg::action_t'(3'd6), 3'd0, 1'b0, 3'd0, '0));
		send(make_item(rsme_pkg::action_t'(3'd7), 3'd7, 1'b1, 3'd7, 32'hFFFF_FFFF));
		send(make_item(rsme_pkg::ACT_CALL, 3'd0, 1'b0, 3'd3, '0));
		send(make_item(rsme_pkg::ACT_CALL, 3'd0, 1'b0, 3'd7, '0));
		send(make_item(rsme_pkg::ACT_RET, 3'd7, 1'b0, 3'd0, '0));
		send(make_item(rsme_pkg::ACT_RET, 3'd3, 1'b0, 3'd0, '0));
		for (int i = 0; i < 11; i++)
			send(make_item(rsme_pkg::ACT_CALL, 3'd1, 1'b0, 3'($urandom_range(4)), '0));
		for (int i = 0; i < 11; i++)
			send(make_item(rsme_pkg::ACT_RET, 3'($urandom_range(7)), 1'b0, 3'd0, '0));
		send(make_item(rsme_pkg::ACT_RET, 3'd6, 1'b0, 3'd0, '0));

		// Hold the output off while instructions keep coming.
		hold_cycles = 300;
		for (int i = 0; i < 8; i++)
			send(random_item());

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 83 : 0;
			recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 14 : 0;
			for (int n = 0; n < 300; n++) begin
				it = random_item();
				send(it);
			end
		end
		in_valid <= 1'b0;
		drain();
		if (fail_count == 0)
			$display("tb_register_stack_machine_execute_top passed");
		else
			$display("tb_register_stack_machine_execute_top failed");
		$finish;
	end
endmodule
